/* rtl/core/refcounted_handle_table_macros.svh */
// Assertion macros used by the checker file of the handle table.
`ifndef REFCOUNTED_HANDLE_TABLE_MACROS_SVH
`define REFCOUNTED_HANDLE_TABLE_MACROS_SVH

// Property checked while reset is released.
`define RHT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property that also covers the reset cycles themselves.
`define RHT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rht_pkg.sv */
package rht_pkg;

    localparam int HANDLE_W = 7;
    localparam int VALUE_W  = 32;
    localparam int OCOUNT_W = 16;

    typedef enum logic [2:0] {
        KIND_CREATE = 3'd0,
        KIND_REF    = 3'd1,
        KIND_UNREF  = 3'd2,
        KIND_RDCNT  = 3'd3,
        KIND_LOOKUP = 3'd4,
        KIND_FIND   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_NONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EXEC,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  item_value;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] out_handle;
        logic [VALUE_W-1:0]  out_value;
        logic [OCOUNT_W-1:0] ref_count;
        logic                released;
    } out_item_t;

endpackage

/* rtl/core/refcounted_handle_table.sv */
// Reference-counted handle table.
// An input item (kind, handle, item_value) arrives on the s_ channel and is
// taken when s_valid and s_ready are both high. Exactly one result item leaves
// on the m_ channel for every input item, in order. The block works on one
// item at a time: s_ready is high only while the sequencer is idle.
// Handle operations (ref, unref, read count, lookup and unknown kinds) go
// through accept, memory read, execute and hand-off to the output register;
// the hand-off waits while a stalled result holds it. Create and find
// scan the flag vectors 16 slots per cycle, one group per scan step, up to
// ceil(TABLE_DEPTH/16) groups (4 at depth 64); a miss skips to the hand-off.
// The single count adder, the flag-group priority encoder and the one
// read/write port of each slot memory set this sequence of steps.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and processed, and its result is held back until
// the output register frees up. Synchronous active-low reset empties every
// slot and the output register; no clearing pass is needed because slot
// contents are read only for valid slots, which a create fills first.
module refcounted_handle_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rht_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rht_pkg::out_item_t m_data
);

    // Flags are scanned in groups of this many slots per cycle.
    localparam int GROUP_W    = 16;
    localparam int POS_W      = $clog2(GROUP_W);
    localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W      = NUM_GROUPS * GROUP_W;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int HXW        = (IDX_W > rht_pkg::HANDLE_W) ? IDX_W : rht_pkg::HANDLE_W;
    localparam int OHW        = (IDX_W + 1 > rht_pkg::HANDLE_W) ? IDX_W + 1 : rht_pkg::HANDLE_W;
    localparam int CXW        = (COUNT_BITS > rht_pkg::OCOUNT_W) ? COUNT_BITS : rht_pkg::OCOUNT_W;

    rht_pkg::state_t    state_reg, state_next;
    rht_pkg::in_item_t  in_reg, in_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] zero_reg, zero_next;
    rht_pkg::out_item_t res_reg, res_next;
    rht_pkg::out_item_t m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    // Slot memories: one write and one registered read at idx_reg.
    logic [COUNT_BITS-1:0]       count_mem [TABLE_DEPTH];
    logic [rht_pkg::VALUE_W-1:0] value_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]       rd_count_reg;
    logic [rht_pkg::VALUE_W-1:0] rd_value_reg;
    logic                        cnt_we;
    logic [COUNT_BITS-1:0]       cnt_wdata;
    logic                        val_we;

    // Scan datapath.
    logic [PAD_W-1:0]    search_vec;
    logic [GROUP_W-1:0]  group_bits;
    logic [POS_W-1:0]    hit_pos;
    logic                hit;
    logic [GRP_W+POS_W-1:0] scan_idx;
    logic                last_group;

    // Handle decode and shared count adder.
    logic [HXW-1:0]        hdl_dec;
    logic                  handle_ok;
    logic                  slot_ok;
    logic                  is_ref;
    logic                  cnt_at_max;
    logic [COUNT_BITS-1:0] cnt_addend;
    logic [COUNT_BITS-1:0] cnt_sum;
    logic [COUNT_BITS-1:0] cnt_report;
    logic [CXW-1:0]        cnt_ext;
    logic [OHW-1:0]        idx_plus1;

    assign s_ready = (state_reg == rht_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The flags searched depend on the operation: free slots for a create,
    // valid slots with a zero count for a find. Padding never matches.
    always_comb begin
        search_vec = '0;
        if (in_reg.kind == rht_pkg::KIND_CREATE) begin
            search_vec[TABLE_DEPTH-1:0] = ~valid_reg;
        end else begin
            search_vec[TABLE_DEPTH-1:0] = valid_reg & zero_reg;
        end
        group_bits = search_vec[grp_reg * GROUP_W +: GROUP_W];
        hit_pos = '0;
        for (int i = GROUP_W - 1; i >= 0; i--) begin
            if (group_bits[i]) begin
                hit_pos = POS_W'(i);
            end
        end
        hit = |group_bits;
    end

    assign scan_idx   = {grp_reg, hit_pos};
    assign last_group = (grp_reg == GRP_W'(NUM_GROUPS - 1));
    assign idx_plus1  = OHW'(idx_reg) + OHW'(1);

    assign hdl_dec   = HXW'(s_data.handle) - HXW'(1);
    assign handle_ok = (in_reg.handle != '0) && (32'(in_reg.handle) <= 32'(TABLE_DEPTH));
    assign slot_ok   = handle_ok && valid_reg[idx_reg];

    // One adder serves both ref (+1) and unref (-1).
    assign is_ref     = (in_reg.kind == rht_pkg::KIND_REF);
    assign cnt_at_max = &rd_count_reg;
    assign cnt_addend = is_ref ? COUNT_BITS'(1) : '1;
    assign cnt_sum    = rd_count_reg + cnt_addend;

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        idx_next     = idx_reg;
        grp_next     = grp_reg;
        valid_next   = valid_reg;
        zero_next    = zero_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        cnt_we       = 1'b0;
        cnt_wdata    = rd_count_reg;
        val_we       = 1'b0;
        cnt_report   = rd_count_reg;
        cnt_ext      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rht_pkg::ST_IDLE: begin
                if (s_valid) begin
                    in_next  = s_data;
                    idx_next = hdl_dec[IDX_W-1:0];
                    grp_next = '0;
                    if (s_data.kind == rht_pkg::KIND_CREATE ||
                        s_data.kind == rht_pkg::KIND_FIND) begin
                        state_next = rht_pkg::ST_SCAN;
                    end else begin
                        state_next = rht_pkg::ST_READ;
                    end
                end
            end
            rht_pkg::ST_SCAN: begin
                if (hit) begin
                    idx_next   = scan_idx[IDX_W-1:0];
                    state_next = rht_pkg::ST_READ;
                end else if (last_group) begin
                    res_next = '0;
                    if (in_reg.kind == rht_pkg::KIND_CREATE) begin
                        res_next.status = rht_pkg::STATUS_FULL;
                    end else begin
                        res_next.status = rht_pkg::STATUS_NONE;
                    end
                    state_next = rht_pkg::ST_PUSH;
                end else begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end
            rht_pkg::ST_READ: begin
                state_next = rht_pkg::ST_EXEC;
            end
            rht_pkg::ST_EXEC: begin
                res_next   = '0;
                state_next = rht_pkg::ST_PUSH;
                priority case (1'b1)
                    (in_reg.kind == rht_pkg::KIND_CREATE): begin
                        valid_next[idx_reg] = 1'b1;
                        zero_next[idx_reg]  = 1'b1;
                        cnt_we              = 1'b1;
                        cnt_wdata           = '0;
                        val_we              = 1'b1;
                        res_next.out_handle = idx_plus1[rht_pkg::HANDLE_W-1:0];
                    end
                    (in_reg.kind == rht_pkg::KIND_FIND): begin
                        res_next.out_handle = idx_plus1[rht_pkg::HANDLE_W-1:0];
                        res_next.out_value  = rd_value_reg;
                    end
                    (!slot_ok): begin
                        res_next.status = rht_pkg::STATUS_INVALID;
                    end
                    (in_reg.kind == rht_pkg::KIND_REF): begin
                        if (!cnt_at_max) begin
                            cnt_we             = 1'b1;
                            cnt_wdata          = cnt_sum;
                            cnt_report         = cnt_sum;
                            zero_next[idx_reg] = 1'b0;
                        end
                        cnt_ext            = CXW'(cnt_report);
                        res_next.ref_count = cnt_ext[rht_pkg::OCOUNT_W-1:0];
                    end
                    (in_reg.kind == rht_pkg::KIND_UNREF): begin
                        if (rd_count_reg == '0) begin
                            // Dropping the last reference frees the slot.
                            valid_next[idx_reg] = 1'b0;
                            res_next.out_value  = rd_value_reg;
                            res_next.released   = 1'b1;
                        end else begin
                            cnt_we             = 1'b1;
                            cnt_wdata          = cnt_sum;
                            zero_next[idx_reg] = (cnt_sum == '0);
                            cnt_ext            = CXW'(cnt_sum);
                            res_next.ref_count = cnt_ext[rht_pkg::OCOUNT_W-1:0];
                        end
                    end
                    (in_reg.kind == rht_pkg::KIND_RDCNT): begin
                        cnt_ext            = CXW'(rd_count_reg);
                        res_next.ref_count = cnt_ext[rht_pkg::OCOUNT_W-1:0];
                    end
                    (in_reg.kind == rht_pkg::KIND_LOOKUP): begin
                        cnt_ext            = CXW'(rd_count_reg);
                        res_next.ref_count = cnt_ext[rht_pkg::OCOUNT_W-1:0];
                        res_next.out_value = rd_value_reg;
                    end
                    default: begin
                        res_next.status = rht_pkg::STATUS_INVALID;
                    end
                endcase
            end
            rht_pkg::ST_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = rht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rht_pkg::ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers; the zero flags only matter for valid slots.
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        idx_reg    <= idx_next;
        grp_reg    <= grp_next;
        zero_reg   <= zero_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[idx_reg] <= cnt_wdata;
        end
        rd_count_reg <= count_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[idx_reg] <= in_reg.item_value;
        end
        rd_value_reg <= value_mem[idx_reg];
    end

endmodule

/* rtl/core/rht_checker.sv */
`include "refcounted_handle_table_macros.svh"

module rht_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rht_pkg::out_item_t m_data
);

    // Reset leaves the block idle with no result pending.
    `RHT_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_valid && s_ready), "not idle after reset")

    // An accepted item keeps the sequencer busy in the cycle after the accept.
    `RHT_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready right after accept")

    // A result stays offered until the receiver takes it.
    `RHT_ASSERT(a_m_valid_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result withdrawn")

    // A stalled result keeps its payload.
    `RHT_ASSERT(a_m_data_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_data), "stalled result changed")

endmodule

bind refcounted_handle_table rht_checker u_rht_checker (.*);

/* tb/refcounted_handle_table_tb.sv */
`timescale 1ns / 1ps

// Shadow copy of the handle table. It applies every accepted request to its
// own slot state and queues the result the block has to return for it.
class handle_table_shadow #(int SLOTS = 64, int CBITS = 16);
    localparam int HANDLE_W = rht_pkg::HANDLE_W;
    localparam int OCOUNT_W = rht_pkg::OCOUNT_W;

    bit                  live[SLOTS];
    logic [CBITS-1:0]    cnt[SLOTS];
    logic [31:0]         val[SLOTS];
    rht_pkg::out_item_t  pending_results[$];
    int                  errors;

    function int occupancy();
        int n;
        n = 0;
        foreach (live[i]) begin
            if (live[i]) n++;
        end
        return n;
    endfunction

    function rht_pkg::out_item_t apply_op(rht_pkg::in_item_t it);
        rht_pkg::out_item_t r;
        int                 idx;
        bit                 hit;
        r = '0;
        r.status = rht_pkg::STATUS_OK;
        hit = 1'b0;
        case (it.kind)
            rht_pkg::KIND_CREATE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && !live[i]) begin
                        hit = 1'b1;
                        live[i] = 1'b1;
                        cnt[i] = '0;
                        val[i] = it.item_value;
                        r.out_handle = HANDLE_W'(i + 1);
                    end
                end
                if (!hit) r.status = rht_pkg::STATUS_FULL;
            end
            rht_pkg::KIND_FIND: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && live[i] && cnt[i] == '0) begin
                        hit = 1'b1;
                        r.out_handle = HANDLE_W'(i + 1);
                        r.out_value = val[i];
                    end
                end
                if (!hit) r.status = rht_pkg::STATUS_NONE;
            end
            default: begin
                if (it.kind > rht_pkg::KIND_FIND || it.handle == '0 || it.handle > SLOTS ||
                    !live[it.handle - 1]) begin
                    r.status = rht_pkg::STATUS_INVALID;
                end else begin
                    idx = int'(it.handle) - 1;
                    case (it.kind)
                        rht_pkg::KIND_REF: begin
                            if (cnt[idx] != '1) cnt[idx] = cnt[idx] + 1'b1;
                            r.ref_count = OCOUNT_W'(cnt[idx]);
                        end
                        rht_pkg::KIND_UNREF: begin
                            if (cnt[idx] == '0) begin
                                live[idx] = 1'b0;
                                r.out_value = val[idx];
                                r.released = 1'b1;
                            end else begin
                                cnt[idx] = cnt[idx] - 1'b1;
                                r.ref_count = OCOUNT_W'(cnt[idx]);
                            end
                        end
                        rht_pkg::KIND_RDCNT: r.ref_count = OCOUNT_W'(cnt[idx]);
                        default: begin
                            r.out_value = val[idx];
                            r.ref_count = OCOUNT_W'(cnt[idx]);
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    function void note_request(rht_pkg::in_item_t it);
        pending_results.push_back(apply_op(it));
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task check_response(rht_pkg::out_item_t got);
        rht_pkg::out_item_t want;
        if (pending_results.size() == 0) begin
            report($sformatf("result %h arrived with no request pending", got));
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.out_handle !== want.out_handle)
                report($sformatf("out_handle %0d, expected %0d",
                                 got.out_handle, want.out_handle));
            if (got.out_value !== want.out_value)
                report($sformatf("out_value %h, expected %h", got.out_value, want.out_value));
            if (got.ref_count !== want.ref_count)
                report($sformatf("ref_count %0d, expected %0d",
                                 got.ref_count, want.ref_count));
            if (got.released !== want.released)
                report($sformatf("released %b, expected %b", got.released, want.released));
        end
    endtask
endclass

module refcounted_handle_table_tb;

    localparam int DEPTH      = 64;
    localparam int CNT_BITS   = 16;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int TAIL_WAIT  = 20;
    localparam int DEEP_REFS  = 40;
    localparam int HANDLE_W   = rht_pkg::HANDLE_W;
    localparam int VALUE_W    = rht_pkg::VALUE_W;

    // The two kind codes the block does not define; both must come back
    // as an invalid-handle status without touching any slot.
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    rht_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rht_pkg::out_item_t m_data;

    handle_table_shadow #(DEPTH, CNT_BITS) shadow;

    // Idle rates in percent for the request side and the result side.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    refcounted_handle_table #(
        .TABLE_DEPTH(DEPTH),
        .COUNT_BITS (CNT_BITS)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every check happens on the sampled, pre-edge values, so the order in
    // which the block's registers and this process run within an edge does
    // not matter. The ready line is redrawn on every edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) shadow.check_response(m_data);
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it. A random gap
    // may come first; valid is only dropped when such a gap is taken, so a
    // back-to-back request never lowers and raises valid in the same step.
    task automatic send_op(input logic [2:0] op, input logic [HANDLE_W-1:0] hdl,
                           input logic [VALUE_W-1:0] value);
        rht_pkg::in_item_t it;
        it.kind = op;
        it.handle = hdl;
        it.item_value = value;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(it);
        items_sent++;
    endtask

    // Stop sending until the block has returned every outstanding result.
    // The loop waits on a clock edge before its first check, so the next request raises valid later.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shadow.pending_results.size() != 0);
    endtask

    // Mostly a live handle so the operation really acts on a slot; now and
    // then any 7-bit handle, which covers zero and the out-of-range ones.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int n;
        int k;
        n = shadow.occupancy();
        if (n == 0 || $urandom_range(0, 99) < 15) return HANDLE_W'($urandom_range(0, 127));
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < DEPTH; i++) begin
            if (shadow.live[i]) begin
                if (k == 0) return HANDLE_W'(i + 1);
                k--;
            end
        end
        return '0;
    endfunction

    // Create until the table is full, plus one or two creates that must
    // report a full table. The handle field is ignored by create.
    task automatic fill_table();
        int n;
        n = DEPTH - shadow.occupancy() + 1 + $urandom_range(0, 1);
        repeat (n) send_op(rht_pkg::KIND_CREATE, HANDLE_W'($urandom_range(0, 127)), $urandom);
    endtask

    // Release slots by unreferencing them one past zero. With only_low set,
    // slots holding a larger count are left alone to keep the burst short.
    task automatic release_slots(input bit only_low);
        for (int i = 0; i < DEPTH; i++) begin
            if (shadow.live[i] && (!only_low || shadow.cnt[i] <= 3))
                repeat (int'(shadow.cnt[i]) + 1)
                    send_op(rht_pkg::KIND_UNREF, HANDLE_W'(i + 1), $urandom);
        end
    endtask

    // Hand-picked opening sequence: empty-table searches, bad handles of
    // every sort, value extremes, a release and reuse of the freed slot,
    // and both undefined kind codes.
    task automatic directed_cases();
        send_op(rht_pkg::KIND_FIND,   7'd0,   32'h0);
        send_op(rht_pkg::KIND_REF,    7'd0,   32'h0);
        send_op(rht_pkg::KIND_LOOKUP, 7'd1,   32'h0);
        send_op(rht_pkg::KIND_CREATE, 7'd0,   32'h0000_0000);
        send_op(rht_pkg::KIND_CREATE, 7'd127, 32'hFFFF_FFFF);
        send_op(rht_pkg::KIND_CREATE, 7'd64,  32'hA5A5_5A5A);
        send_op(rht_pkg::KIND_REF,    7'd1,   32'hFFFF_FFFF);
        send_op(rht_pkg::KIND_REF,    7'd65,  32'h0);
        send_op(rht_pkg::KIND_UNREF,  7'd127, 32'h0);
        send_op(rht_pkg::KIND_RDCNT,  7'd1,   32'h0);
        send_op(rht_pkg::KIND_LOOKUP, 7'd2,   32'h0);
        // The lowest slot with a zero count is now handle 2.
        send_op(rht_pkg::KIND_FIND,   7'd0,   32'h0);
        send_op(rht_pkg::KIND_UNREF,  7'd2,   32'h0);
        send_op(rht_pkg::KIND_LOOKUP, 7'd2,   32'h0);
        send_op(rht_pkg::KIND_RDCNT,  7'd64,  32'h0);
        // The freed slot must be the one handed out again.
        send_op(rht_pkg::KIND_CREATE, 7'd0,   32'h1234_5678);
        send_op(KIND_UNUSED_6, 7'd1, 32'hFFFF_FFFF);
        send_op(KIND_UNUSED_7, 7'd1, 32'h0);
        send_op(rht_pkg::KIND_UNREF,  7'd1,   32'h0);
        send_op(rht_pkg::KIND_UNREF,  7'd1,   32'h0);
        send_op(rht_pkg::KIND_LOOKUP, 7'd3,   32'h0);
        send_op(rht_pkg::KIND_FIND,   7'd0,   32'h0);
    endtask

    // Random traffic built from short, well-formed sequences: a reference
    // burst that refs a handle, reads it back and unrefs it (often past zero),
    // table fills, releases, pauses, raw noise and single operations.
    task automatic random_traffic(input int n_items);
        int                  stop_at;
        int                  pick;
        int                  reps;
        logic [2:0]          op;
        logic [HANDLE_W-1:0] h;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                fill_table();
            end else if (pick < 10) begin
                release_slots(1'b1);
            end else if (pick < 26) begin
                h = pick_handle();
                reps = $urandom_range(1, 6);
                repeat (reps) send_op(rht_pkg::KIND_REF, h, $urandom);
                send_op(rht_pkg::KIND_RDCNT, h, $urandom);
                repeat ($urandom_range(1, reps + 2)) send_op(rht_pkg::KIND_UNREF, h, $urandom);
            end else if (pick < 30) begin
                wait_drained();
            end else if (pick < 42) begin
                send_op(3'($urandom_range(0, 7)), HANDLE_W'($urandom_range(0, 127)), $urandom);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20)      op = rht_pkg::KIND_CREATE;
                else if (pick < 40) op = rht_pkg::KIND_REF;
                else if (pick < 62) op = rht_pkg::KIND_UNREF;
                else if (pick < 72) op = rht_pkg::KIND_RDCNT;
                else if (pick < 84) op = rht_pkg::KIND_LOOKUP;
                else                op = rht_pkg::KIND_FIND;
                send_op(op, pick_handle(), $urandom);
            end
        end
    endtask

    // Drive one slot's count up with a long run of refs, read it back, look
    // it up and step it down, then search while the only live slot is busy.
    task automatic deep_count_one_slot();
        send_op(rht_pkg::KIND_CREATE, 7'd0, 32'hDEAD_BEEF);
        repeat (DEEP_REFS) send_op(rht_pkg::KIND_REF, 7'd1, $urandom);
        send_op(rht_pkg::KIND_RDCNT,  7'd1, 32'h0);
        send_op(rht_pkg::KIND_REF,    7'd1, 32'h0);
        send_op(rht_pkg::KIND_LOOKUP, 7'd1, 32'h0);
        send_op(rht_pkg::KIND_UNREF,  7'd1, 32'h0);
        // Only slot 1 is live and its count is far from zero.
        send_op(rht_pkg::KIND_FIND,   7'd0, 32'h0);
    endtask

    initial begin
        shadow = new;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: a slow sender against a receiver that stalls often.
        tx_idle_pct = 38;
        rx_idle_pct = 77;
        directed_cases();
        fill_table();
        random_traffic(70);
        wait_drained();

        // Phase two: the rates swapped.
        tx_idle_pct = 77;
        rx_idle_pct = 38;
        release_slots(1'b0);
        fill_table();
        random_traffic(80);
        wait_drained();

        // Phase three: no idling at all. The table is emptied first so the
        // heavily referenced slot is handle 1.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        release_slots(1'b0);
        deep_count_one_slot();
        random_traffic(70);
        wait_drained();

        // Keep watching the result channel after the last result so that a stray
        // extra result from the block can still show.
        repeat (TAIL_WAIT) @(posedge aclk);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
